/* src/bba_pkg.sv */
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

   localparam int WORD_W    = 32;   // map bits fetched per memory word
   localparam int BIT_W     = 5;    // bit position within a word
   localparam int POS_W     = 10;   // block index width
   localparam int LIM_W     = 11;   // block count width, holds 1024
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;
   localparam int MAP_LIMIT = 1024; // highest block count the index fields can address

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_MARK  = 2'd2;
   localparam logic [1:0] REQ_TEST  = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOFREE = 2'd1;
   localparam logic [1:0] STAT_RANGE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DATA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS = 2'd1;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_sel;
   } scan_result_type;

endpackage

/* src/bba_word_scan.sv */
// Finds the lowest free bit of one map word that lies inside a block range.
module bba_word_scan
   import bba_pkg::*;
#(
   parameter int WORD_AW = 5
) (
   input  logic [WORD_AW-1:0] word_addr,
   input  logic [WORD_W-1:0]  word_data,
   input  logic [LIM_W-1:0]   range_lo,
   input  logic [LIM_W-1:0]   range_hi,
   output scan_result_type    result
);

   logic [WORD_W-1:0] cand;

   always_comb begin
      logic [LIM_W-1:0] pos;
      for (int i = 0; i < WORD_W; i++) begin
         pos     = LIM_W'({word_addr, BIT_W'(i)});
         cand[i] = !word_data[i] && (pos >= range_lo) && (pos < range_hi);
      end
   end

   // Lowest candidate wins: the loop runs downwards through the word and keeps the last match.
   always_comb begin
      result.found   = 1'b0;
      result.bit_sel = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (cand[i]) begin
            result.found   = 1'b1;
            result.bit_sel = BIT_W'(i);
         end
      end
   end

endmodule

/* src/bitmap_block_allocator.sv */
// Top level of the bitmap block allocator: map memory, search pointer and sequencer.
//
//   channel  direction  signals                                    handshake
//   req      in         req_type, req_block_index                  req_valid / req_ready
//   rsp      out        rsp_status, rsp_result_block, rsp_was_used rsp_valid / rsp_ready
//   csr      in         csr_index, csr_wdata                       csr_we, no wait
//
// Free, mark and test go through the lookup, scan and response states; an index out of range,
// or an allocate with no data area, goes straight to the response state. An allocate reads the
// map one 32-bit word at a time from the search pointer up, through the single word-scan unit
// and the one map read port; a wrapping search goes on from the first data block and can read
// the pointer's word twice. Reset clears every word at once through per-word valid bits. A new
// transaction is accepted while a response still waits, and the block then stalls in its
// response state until the output register is free.
module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [POS_W-1:0]     req_block_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [POS_W-1:0]     rsp_result_block,
   output logic                 rsp_was_used,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int MAP_BITS = (MAX_BLOCKS < MAP_LIMIT) ? MAX_BLOCKS : MAP_LIMIT;
   localparam int WORDS    = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int WORD_AW  = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         rtype_ff, rtype_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic [POS_W-1:0]   ptr_ff, ptr_in;
   logic [POS_W-1:0]   fdb_ff, fdb_in;
   logic [LIM_W-1:0]   num_ff, num_in;
   logic [WORD_AW-1:0] cur_ff, cur_in;
   logic               phase_ff, phase_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [POS_W-1:0]   res_block_ff, res_block_in;
   logic               res_was_ff, res_was_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_block_ff, rsp_block_in;
   logic               rsp_was_ff, rsp_was_in;

   logic [WORD_W-1:0]  map_mem [WORDS];
   logic [WORDS-1:0]   valid_ff;
   logic [WORD_W-1:0]  rdata_ff;
   logic               word_valid_ff;
   logic [WORD_AW-1:0] rd_addr;
   logic               wr_en;
   logic [WORD_W-1:0]  wr_data;

   logic [LIM_W-1:0]   lim;
   logic [LIM_W-1:0]   fdb_ext;
   logic [LIM_W-1:0]   ptr_ext;
   logic [LIM_W-1:0]   scan_lo;
   logic [LIM_W-1:0]   scan_hi;
   logic [LIM_W-1:0]   scan_hi_m1;
   logic [WORD_AW-1:0] last_word;
   logic [WORD_W-1:0]  rword;
   logic [POS_W-1:0]   found_pos;
   logic               accept;
   scan_result_type    scan_res;

   assign req_ready        = (state_ff == ST_IDLE);
   assign accept           = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_was_used     = rsp_was_ff;

   assign lim     = (num_ff < LIM_W'(MAP_BITS)) ? num_ff : LIM_W'(MAP_BITS);
   assign fdb_ext = {1'b0, fdb_ff};
   assign ptr_ext = {1'b0, ptr_ff};

   // The first pass runs from the pointer to the top, the second from the first data
   // block up to the pointer.
   assign scan_lo    = phase_ff ? fdb_ext : ptr_ext;
   assign scan_hi    = phase_ff ? ptr_ext : lim;
   assign scan_hi_m1 = scan_hi - LIM_W'(1);
   assign last_word  = scan_hi_m1[WORD_AW+BIT_W-1:BIT_W];

   // A word never written since reset reads as all free.
   assign rword     = word_valid_ff ? rdata_ff : '0;
   assign found_pos = POS_W'({cur_ff, scan_res.bit_sel});

   bba_word_scan #(
      .WORD_AW (WORD_AW)
   ) u_scan (
      .word_addr (cur_ff),
      .word_data (rword),
      .range_lo  (scan_lo),
      .range_hi  (scan_hi),
      .result    (scan_res)
   );

   always_comb begin
      logic [POS_W-1:0] start;
      logic [WORD_W-1:0] bit_mask;
      state_in      = state_ff;
      rtype_in      = rtype_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      fdb_in        = fdb_ff;
      num_in        = num_ff;
      cur_in        = cur_ff;
      phase_in      = phase_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_was_in    = res_was_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_was_in    = rsp_was_ff;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_data       = rword;
      start         = (ptr_ext >= lim) ? fdb_ff : ptr_ff;
      bit_mask      = WORD_W'(1) << idx_ff[BIT_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               case (csr_index)
                  CSR_FIRST_DATA: begin
                     fdb_in = csr_wdata[POS_W-1:0];
                     ptr_in = csr_wdata[POS_W-1:0];
                  end
                  CSR_NUM_BLOCKS: num_in = csr_wdata;
                  default: ;
               endcase
            end
            if (accept) begin
               rtype_in = req_type;
               idx_in   = req_block_index;
               phase_in = 1'b0;
               if (req_type == REQ_ALLOC) begin
                  if (fdb_ext >= lim) begin
                     res_status_in = STAT_NOFREE;
                     res_block_in  = '0;
                     res_was_in    = 1'b0;
                     state_in      = ST_RESP;
                  end else begin
                     ptr_in   = start;
                     cur_in   = start[WORD_AW+BIT_W-1:BIT_W];
                     state_in = ST_LOOKUP;
                  end
               end else if ({1'b0, req_block_index} >= lim) begin
                  res_status_in = STAT_RANGE;
                  res_block_in  = req_block_index;
                  res_was_in    = 1'b0;
                  state_in      = ST_RESP;
               end else begin
                  cur_in   = req_block_index[WORD_AW+BIT_W-1:BIT_W];
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (rtype_ff != REQ_ALLOC) begin
               wr_en         = (rtype_ff == REQ_FREE) || (rtype_ff == REQ_MARK);
               wr_data       = (rtype_ff == REQ_FREE) ? (rword & ~bit_mask)
                                                      : (rword | bit_mask);
               res_status_in = STAT_OK;
               res_block_in  = idx_ff;
               res_was_in    = rword[idx_ff[BIT_W-1:0]];
               state_in      = ST_RESP;
            end else if (scan_res.found) begin
               wr_en         = 1'b1;
               wr_data       = rword | (WORD_W'(1) << scan_res.bit_sel);
               ptr_in        = found_pos;
               res_status_in = STAT_OK;
               res_block_in  = found_pos;
               res_was_in    = 1'b0;
               state_in      = ST_RESP;
            end else if (cur_ff == last_word) begin
               if (!phase_ff && (ptr_ff != fdb_ff)) begin
                  phase_in = 1'b1;
                  cur_in   = fdb_ff[WORD_AW+BIT_W-1:BIT_W];
                  rd_addr  = fdb_ff[WORD_AW+BIT_W-1:BIT_W];
               end else begin
                  res_status_in = STAT_NOFREE;
                  res_block_in  = '0;
                  res_was_in    = 1'b0;
                  state_in      = ST_RESP;
               end
            end else begin
               cur_in  = cur_ff + WORD_AW'(1);
               rd_addr = cur_ff + WORD_AW'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               rsp_was_in    = res_was_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= POS_W'(2);
         fdb_ff       <= POS_W'(2);
         num_ff       <= LIM_W'(MAP_LIMIT);
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fdb_ff       <= fdb_in;
         num_ff       <= num_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff      <= rtype_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_was_ff    <= res_was_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_was_ff    <= rsp_was_in;
   end

   // Map storage: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[cur_ff] <= wr_data;
      end
      rdata_ff      <= map_mem[rd_addr];
      word_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[cur_ff] <= 1'b1;
      end
   end

   // The search pointer never drops below the first data block.
   a_ptr_floor: assert property (@(posedge clock) disable iff (reset)
      ptr_ff >= fdb_ff)
      else $error("search pointer below first data block");

   // A block handed out by the scan lies inside the range of the current pass.
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (rtype_ff == REQ_ALLOC) && scan_res.found
      |-> ({1'b0, found_pos} >= scan_lo) && ({1'b0, found_pos} < scan_hi))
      else $error("allocated block outside the search range");

   // An accepted transaction always takes the block out of the idle state in the cycle after it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready still high after accepting a transaction");

endmodule
